// ----- hdl/positional_list_engine_top_defines.svh -----
// Assertion macros for the positional list engine top level.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional list engine check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional list engine check failed");

`endif

// ----- hdl/ple_pkg.sv -----
// Shared types, constants and helpers for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int CMP_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    localparam logic signed [31:0] EMPTY_LARGEST = 32'shC0C0C0C1;

    typedef enum logic [2:0] {
        ACT_CLEAR     = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_DELETE    = 3'd2,
        ACT_SORT_ASC  = 3'd3,
        ACT_SORT_DESC = 3'd4,
        ACT_READ      = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_SORT   = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         length;
        logic signed [31:0] largest;
    } t_result;

    typedef struct packed {
        t_cell_op           op;
        logic               desc;
        logic               phase;
        logic [IDX_W-1:0]   p;
        logic [LEN_W-1:0]   len;
        logic signed [31:0] value;
    } t_cell_cmd;

    typedef struct packed {
        logic               has;
        logic signed [31:0] pm;
        logic signed [31:0] rd;
    } t_link;

    function automatic logic lt(input logic signed [31:0] a, input logic signed [31:0] b);
        return a < b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ple_cell.sv -----
// One list cell: holds an entry, shifts or swaps with neighbors, forwards max and read data.
`default_nettype none

module ple_cell import ple_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic [IDX_W-1:0]   i_idx,
    input  wire t_cell_cmd          i_cmd,
    input  wire logic signed [31:0] i_left,
    input  wire logic signed [31:0] i_right,
    input  wire t_link              i_link,
    output logic signed [31:0]      o_v,
    output t_link                   o_link
);

    logic signed [31:0] r_v;
    logic signed [31:0] n_v;
    t_link              r_link;
    t_link              n_link;
    logic [LEN_W-1:0]   w_idx;
    logic               w_valid;
    logic               w_lower;
    logic               w_pair_right;
    logic               w_pair_left;

    assign w_idx        = LEN_W'(i_idx);
    assign w_valid      = w_idx < i_cmd.len;
    assign w_lower      = (i_idx[0] == i_cmd.phase);
    assign w_pair_right = (w_idx + LEN_W'(1)) < i_cmd.len;
    assign w_pair_left  = (i_idx != '0) && w_valid;

    always_comb begin
        n_v = r_v;
        case (i_cmd.op)
            OP_INSERT: begin
                if (i_idx > i_cmd.p) begin
                    n_v = i_left;
                end else if (i_idx == i_cmd.p) begin
                    n_v = i_cmd.value;
                end
            end
            OP_DELETE: begin
                if (i_idx >= i_cmd.p) begin
                    n_v = i_right;
                end
            end
            OP_SORT: begin
                if (w_lower && w_pair_right) begin
                    if (i_cmd.desc ? lt(r_v, i_right) : lt(i_right, r_v)) begin
                        n_v = i_right;
                    end
                end else if (!w_lower && w_pair_left) begin
                    if (i_cmd.desc ? lt(i_left, r_v) : lt(r_v, i_left)) begin
                        n_v = i_left;
                    end
                end
            end
            default: n_v = r_v;
        endcase
    end

    always_comb begin
        n_link = i_link;
        if (w_valid) begin
            n_link.has = 1'b1;
            n_link.pm  = (i_link.has && lt(r_v, i_link.pm)) ? i_link.pm : r_v;
        end
        if (i_idx == i_cmd.p) begin
            n_link.rd = r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_link <= n_link;
    end

    assign o_v    = r_v;
    assign o_link = r_link;

endmodule

`default_nettype wire

// ----- hdl/ple_chain.sv -----
// Row of list cells wired to their neighbors.
`default_nettype none

module ple_chain import ple_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    output t_link          o_link
);

    logic signed [31:0] w_v    [DEPTH];
    t_link              w_link [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        t_link              w_in;

        if (g == 0) begin : g_first
            assign w_left = '0;
            assign w_in   = '0;
        end else begin : g_inner
            assign w_left = w_v[g-1];
            assign w_in   = w_link[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_v[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_cmd   (i_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_link  (w_in),
            .o_v     (w_v[g]),
            .o_link  (w_link[g])
        );
    end

    assign o_link = w_link[DEPTH-1];

endmodule

`default_nettype wire

// ----- hdl/positional_list_engine_top.sv -----
// Top level of the positional list engine: request decode, sequencer and cell row.
// After accept the sequencer runs S_OP, S_SORT (sorts only) and S_SETTLE; S_DONE raises the strobe.
// A new request is taken only when idle, since busy stays high until then; max and read data
// ripple through the DEPTH-cell chain, and a sort runs DEPTH odd-even transposition phases.
// Reset clears the length and the sequencer; list entries are left as they are.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top import ple_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_request i_req,
    output logic          busy,
    output logic          o_done,
    output t_result       o_res
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_OP     = 5'b00010,
        S_SORT   = 5'b00100,
        S_SETTLE = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   n_cnt;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    t_action            r_act;
    t_status            r_status;
    t_status            w_status;
    logic [IDX_W-1:0]   r_p;
    logic signed [31:0] r_val;
    logic               r_rd_en;
    logic               w_accept;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_len;
    t_cell_cmd          w_cmd;
    t_link              w_last;

    assign w_accept = start && !busy;
    assign w_pos    = CMP_W'(i_req.position);
    assign w_len    = CMP_W'(r_len);

    always_comb begin
        w_status = ST_OK;
        unique case (i_req.action)
            ACT_INSERT: begin
                if (w_pos == '0 || w_pos > w_len + CMP_W'(1)) begin
                    w_status = ST_RANGE;
                end else if (w_len >= CMP_W'(DEPTH)) begin
                    w_status = ST_FULL;
                end
            end
            ACT_DELETE, ACT_READ: begin
                if (w_pos == '0 || w_pos > w_len) begin
                    w_status = ST_RANGE;
                end
            end
            default: w_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act    <= t_action'(i_req.action);
            r_status <= w_status;
            r_p      <= IDX_W'(w_pos - CMP_W'(1));
            r_val    <= i_req.value;
            r_rd_en  <= (i_req.action == ACT_READ) && (w_status == ST_OK);
        end
    end

    always_comb begin
        w_cmd       = '0;
        w_cmd.op    = OP_HOLD;
        w_cmd.desc  = (r_act == ACT_SORT_DESC);
        w_cmd.phase = r_cnt[0];
        w_cmd.p     = r_p;
        w_cmd.len   = r_len;
        w_cmd.value = r_val;
        if (r_state == S_OP && r_status == ST_OK) begin
            unique case (r_act)
                ACT_INSERT: w_cmd.op = OP_INSERT;
                ACT_DELETE: w_cmd.op = OP_DELETE;
                default:    w_cmd.op = OP_HOLD;
            endcase
        end else if (r_state == S_SORT) begin
            w_cmd.op = OP_SORT;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_len   = r_len;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_OP;
                end
            end
            S_OP: begin
                n_cnt = '0;
                if (r_status == ST_OK) begin
                    unique case (r_act)
                        ACT_CLEAR:  n_len = '0;
                        ACT_INSERT: n_len = r_len + LEN_W'(1);
                        ACT_DELETE: n_len = r_len - LEN_W'(1);
                        default:    n_len = r_len;
                    endcase
                end
                if (r_act == ACT_SORT_ASC || r_act == ACT_SORT_DESC) begin
                    n_state = S_SORT;
                end else begin
                    n_state = S_SETTLE;
                end
            end
            S_SORT: begin
                n_cnt = r_cnt + IDX_W'(1);
                if (r_cnt == IDX_W'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                n_cnt = r_cnt + IDX_W'(1);
                if (r_cnt == IDX_W'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
        end
    end

    ple_chain u_chain (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_link (w_last)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_res.status     = r_status;
        o_res.read_value = r_rd_en ? w_last.rd : '0;
        o_res.length     = 7'(r_len);
        o_res.largest    = (r_len == '0) ? EMPTY_LARGEST : w_last.pm;
    end

    `PLE_ASSERT_NEXT(a_done_one_cycle, o_done, !o_done)
    `PLE_ASSERT_NEXT(a_accept_starts_op, w_accept, busy && !o_done && r_state == S_OP)
    `PLE_ASSERT_SAME(a_len_bounded, 1'b1, r_len <= LEN_W'(DEPTH))
    `PLE_ASSERT_SAME(a_full_at_depth, o_done && o_res.status == ST_FULL, r_len == LEN_W'(DEPTH))

endmodule

`default_nettype wire

// ----- test/positional_list_engine_top_test.sv -----
// Self-checking testbench for the positional list engine: queued requests, predictor, result checks.
`default_nettype none

module positional_list_engine_top_test import ple_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int SORT_LATENCY = 2 * DEPTH + 3;
    localparam int WATCHDOG_LIMIT = 20 * SORT_LATENCY;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct {
        t_request req;
        bit       drain;
    } t_queued_req;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    t_request i_req = '0;
    logic     busy;
    logic     o_done;
    t_result  o_res;

    t_queued_req        req_queue[$];
    t_result            want_results[$];
    logic signed [31:0] list_mem[DEPTH];
    int                 list_len = 0;
    int                 gen_len = 0;
    int                 n_accepted = 0;
    int                 n_results = 0;
    int                 n_errors = 0;
    int                 hold_cycles = 0;
    int                 idle_cycles = 0;

    positional_list_engine_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    function automatic t_result step_list(input t_request rq);
        t_result            r;
        int                 p;
        int                 i;
        int                 j;
        bit                 desc;
        logic signed [31:0] tmp;
        r = '0;
        r.status = ST_OK;
        p = rq.position;
        desc = (rq.action == ACT_SORT_DESC);
        case (rq.action)
            ACT_CLEAR: list_len = 0;
            ACT_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    r.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = rq.value;
                    list_len++;
                end
            end
            ACT_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
                    list_len--;
                end
            end
            ACT_SORT_ASC, ACT_SORT_DESC: begin
                for (i = 0; i < list_len - 1; i++) begin
                    for (j = 0; j < list_len - 1 - i; j++) begin
                        if (desc ? (list_mem[j] < list_mem[j+1]) :
                                   (list_mem[j] > list_mem[j+1])) begin
                            tmp = list_mem[j];
                            list_mem[j] = list_mem[j+1];
                            list_mem[j+1] = tmp;
                        end
                    end
                end
            end
            ACT_READ: begin
                if (p < 1 || p > list_len) r.status = ST_RANGE;
                else r.read_value = list_mem[p-1];
            end
            default: ;
        endcase
        r.length = list_len[6:0];
        r.largest = EMPTY_LARGEST;
        if (list_len > 0) begin
            r.largest = list_mem[0];
            for (i = 1; i < list_len; i++)
                if (list_mem[i] > r.largest) r.largest = list_mem[i];
        end
        return r;
    endfunction

    task automatic push_request(input logic [2:0] act, input int pos,
                                input logic signed [31:0] val, input bit drain);
        t_queued_req q;
        int          p;
        p = pos & 127;
        q.req.action = act;
        q.req.position = p[6:0];
        q.req.value = val;
        q.drain = drain;
        req_queue.push_back(q);
        case (act)
            ACT_CLEAR: gen_len = 0;
            ACT_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < DEPTH) gen_len++;
            ACT_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        int v;
        case ($urandom_range(0, 9))
            0, 1: begin
                v = $urandom_range(0, 6);
                return v - 3;
            end
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            4: return EMPTY_LARGEST + $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random_op(input bit drain);
        int r;
        int bad;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0: bad = 0;
            1: bad = gen_len + 1;
            2: bad = gen_len + 2;
            3: bad = 127;
            default: bad = $urandom_range(0, 127);
        endcase
        if (r < 25) begin
            push_request(ACT_INSERT, $urandom_range(1, gen_len + 1), pick_value(), drain);
        end else if (r < 40 && gen_len > 0) begin
            push_request(ACT_DELETE, $urandom_range(1, gen_len), $urandom, drain);
        end else if (r < 60 && gen_len > 0) begin
            push_request(ACT_READ, $urandom_range(1, gen_len), $urandom, drain);
        end else if (r < 68) begin
            push_request(ACT_SORT_ASC, $urandom_range(0, 127), $urandom, drain);
        end else if (r < 76) begin
            push_request(ACT_SORT_DESC, $urandom_range(0, 127), $urandom, drain);
        end else if (r < 84) begin
            case ($urandom_range(0, 2))
                0: push_request(ACT_INSERT, (bad == gen_len + 1) ? 0 : bad, pick_value(), drain);
                1: push_request(ACT_DELETE, bad, $urandom, drain);
                default: push_request(ACT_READ, bad, $urandom, drain);
            endcase
        end else if (r < 94) begin
            push_request(3'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom, drain);
        end else begin
            push_request(ACT_CLEAR, $urandom_range(0, 127), $urandom, drain);
        end
    endtask

    task automatic push_full_sequence();
        push_request(ACT_CLEAR, $urandom_range(0, 127), $urandom, 1'b1);
        while (gen_len < DEPTH) begin
            if ($urandom_range(0, 3) == 0)
                push_request(ACT_INSERT, $urandom_range(1, gen_len + 1), pick_value(), 1'b0);
            else
                push_request(ACT_INSERT, gen_len + 1, pick_value(), 1'b0);
        end
        push_request(ACT_INSERT, $urandom_range(1, DEPTH + 1), pick_value(), 1'b0);
        push_request(ACT_INSERT, DEPTH + 1, pick_value(), 1'b0);
        push_request(ACT_INSERT, DEPTH + 2, pick_value(), 1'b0);
        push_request(ACT_INSERT, 0, pick_value(), 1'b0);
        push_request(ACT_READ, DEPTH, 0, 1'b0);
        push_request(ACT_READ, DEPTH + 1, 0, 1'b0);
        push_request(ACT_SORT_ASC, 0, 0, 1'b0);
        push_request(ACT_READ, 1, 0, 1'b0);
        push_request(ACT_READ, DEPTH, 0, 1'b0);
        push_request(ACT_SORT_DESC, 0, 0, 1'b0);
        push_request(ACT_READ, 1, 0, 1'b0);
        push_request(ACT_DELETE, DEPTH, 0, 1'b0);
        push_request(ACT_INSERT, $urandom_range(1, DEPTH), pick_value(), 1'b0);
        push_request(ACT_DELETE, $urandom_range(1, DEPTH), 0, 1'b0);
        push_request(ACT_DELETE, 1, 0, 1'b0);
    endtask

    initial begin
        int n_ops;
        push_request(ACT_READ, 1, 0, 1'b0);
        push_request(ACT_DELETE, 0, 0, 1'b0);
        push_request(ACT_INSERT, 2, 32'sh12345678, 1'b0);
        push_request(ACT_INSERT, 0, 32'sh12345678, 1'b0);
        push_request(ACT_SORT_ASC, 127, 32'shffffffff, 1'b0);
        push_request(ACT_SORT_DESC, 1, 0, 1'b0);
        push_request(ACT_INSERT, 1, 32'sh80000000, 1'b0);
        push_request(ACT_INSERT, 2, 32'shC0C0C0C0, 1'b0);
        push_request(ACT_READ, 2, 0, 1'b0);
        push_request(ACT_INSERT, 1, 32'sh7fffffff, 1'b0);
        push_request(ACT_INSERT, 4, -1, 1'b0);
        push_request(ACT_INSERT, 3, 0, 1'b0);
        push_request(ACT_SPARE_6, 127, $urandom, 1'b1);
        push_request(ACT_SPARE_7, 0, $urandom, 1'b0);
        push_request(ACT_SORT_ASC, 0, 0, 1'b0);
        push_request(ACT_READ, 1, 0, 1'b0);
        push_request(ACT_READ, 5, 0, 1'b0);
        push_request(ACT_READ, 6, 0, 1'b0);
        push_request(ACT_READ, 127, 0, 1'b0);
        push_request(ACT_SORT_DESC, 0, 0, 1'b0);
        push_request(ACT_DELETE, 1, 0, 1'b0);
        push_request(ACT_DELETE, 4, 0, 1'b0);
        push_request(ACT_DELETE, 9, 0, 1'b0);
        push_request(ACT_CLEAR, 127, 32'sh7fffffff, 1'b0);
        push_request(ACT_READ, 1, 0, 1'b0);

        push_full_sequence();
        while (req_queue.size() < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 9) == 0) begin
                push_full_sequence();
            end else begin
                if ($urandom_range(0, 9) < 7)
                    push_request(ACT_CLEAR, $urandom_range(0, 127), $urandom,
                                 $urandom_range(0, 7) == 0);
                n_ops = $urandom_range(0, 10);
                repeat (n_ops) push_request(ACT_INSERT, gen_len + 1, pick_value(), 1'b0);
                n_ops = $urandom_range(3, 12);
                repeat (n_ops) push_random_op(1'b0);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (req_queue.size() != 0 || start || n_results < n_accepted) @(negedge i_clk);
        repeat (SORT_LATENCY + 8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_queued_req nxt;
        bit          take;
        bit          pace_on;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = !start;
            pace_on = !(n_accepted >= 400 && n_accepted < 600);
            if (start && !busy) begin
                want_results.push_back(step_list(i_req));
                n_accepted++;
                take = 1'b1;
                if (pace_on && $urandom_range(0, 99) < 37)
                    hold_cycles = $urandom_range(1, SORT_LATENCY + 3);
            end
            if (take) begin
                if (hold_cycles > 0) begin
                    hold_cycles--;
                    start <= 1'b0;
                end else if (req_queue.size() > 0 &&
                             (!req_queue[0].drain || n_results >= n_accepted)) begin
                    nxt = req_queue.pop_front();
                    i_req <= nxt.req;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            n_results <= n_results + 1;
            if (want_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: %p", o_res));
            end else begin
                want = want_results.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_res.status, want.status));
                if (o_res.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %0d want %0d",
                                              o_res.read_value, want.read_value));
                if (o_res.length !== want.length)
                    report_mismatch($sformatf("length got %0d want %0d",
                                              o_res.length, want.length));
                if (o_res.largest !== want.largest)
                    report_mismatch($sformatf("largest got %0d want %0d",
                                              o_res.largest, want.largest));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
